// ----- rtl/dmn_pkg.sv -----
`default_nettype none

package dmn_pkg;

    // Fixed system sizes
    localparam int MAX_NODES      = 16;
    localparam int RESOURCE_COUNT = 256;
    localparam int NODE_CAP_INT   = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam logic [4:0] NODE_CAP = 5'(NODE_CAP_INT);

    // Field widths
    localparam int KIND_W  = 2;
    localparam int NODE_W  = 4;
    localparam int CNT_W   = 5;
    localparam int STAMP_W = 32;
    localparam int RES_W   = 8;
    localparam int MASK_W  = 16;
    localparam int DATA_W  = 48;
    localparam int PC_W    = 5;

    // Configuration register indexes
    localparam logic CFG_NODE_ID    = 1'b0;
    localparam logic CFG_NODE_COUNT = 1'b1;

    // Input item kinds
    typedef enum logic [KIND_W-1:0] {
        RT_LOCAL_REQ = 2'd0,
        RT_RECV_REQ  = 2'd1,
        RT_RECV_PERM = 2'd2,
        RT_RELEASE   = 2'd3
    } t_req_type;

    // Outgoing message kinds
    typedef enum logic [KIND_W-1:0] {
        MK_REQUEST    = 2'd0,
        MK_PERMISSION = 2'd1,
        MK_GRANT      = 2'd2
    } t_msg_kind;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_RECV_CLK  = 4'd2,
        OP_SET_DEFER = 4'd3,
        OP_EMIT_PERM = 4'd4,
        OP_DEC_PEND  = 4'd5,
        OP_EMIT_GRNT = 4'd6,
        OP_START_REQ = 4'd7,
        OP_SEND_REQ  = 4'd8,
        OP_START_REL = 4'd9,
        OP_SEND_REL  = 4'd10,
        OP_END_REL   = 4'd11
    } t_op;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER      = 4'd0,
        C_ALWAYS     = 4'd1,
        C_NO_INPUT   = 4'd2,
        C_KIND_REL   = 4'd3,
        C_KIND_LREQ  = 4'd4,
        C_IGNORE     = 4'd5,
        C_KIND_PERM  = 4'd6,
        C_NOT_DEFER  = 4'd7,
        C_NO_GRANT   = 4'd8,
        C_WANTED     = 4'd9,
        C_NOT_WANTED = 4'd10,
        C_REQ_MORE   = 4'd11,
        C_REL_MORE   = 4'd12
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_uword;

    // Command from sequencer to datapath
    typedef struct packed {
        t_op  op;
        logic en;
    } t_cmd;

    // Status from datapath to sequencer
    typedef struct packed {
        logic has_input;
        logic kind_rel;
        logic kind_lreq;
        logic ignore;
        logic kind_perm;
        logic no_defer;
        logic no_grant;
        logic wanted;
        logic req_more;
        logic rel_more;
        logic emit_want;
        logic mask_any;
    } t_stat;

    typedef struct packed {
        t_msg_kind          kind;
        logic [NODE_W-1:0]  dest;
        logic [STAMP_W-1:0] stamp;
        logic [RES_W-1:0]   res;
        logic               last;
    } t_msg;

    // Program step addresses
    localparam logic [PC_W-1:0] ST_WAIT      = 5'd0;
    localparam logic [PC_W-1:0] ST_CHK_REL   = 5'd1;
    localparam logic [PC_W-1:0] ST_CHK_LREQ  = 5'd2;
    localparam logic [PC_W-1:0] ST_CHK_IGN   = 5'd3;
    localparam logic [PC_W-1:0] ST_RECV      = 5'd4;
    localparam logic [PC_W-1:0] ST_CHK_DEF   = 5'd5;
    localparam logic [PC_W-1:0] ST_DEFER     = 5'd6;
    localparam logic [PC_W-1:0] ST_PERM_NOW  = 5'd7;
    localparam logic [PC_W-1:0] ST_PERM_IN   = 5'd8;
    localparam logic [PC_W-1:0] ST_GRANT     = 5'd9;
    localparam logic [PC_W-1:0] ST_LREQ      = 5'd10;
    localparam logic [PC_W-1:0] ST_REQ_INIT  = 5'd11;
    localparam logic [PC_W-1:0] ST_REQ_LOOP  = 5'd12;
    localparam logic [PC_W-1:0] ST_REQ_DONE  = 5'd13;
    localparam logic [PC_W-1:0] ST_REL       = 5'd14;
    localparam logic [PC_W-1:0] ST_REL_INIT  = 5'd15;
    localparam logic [PC_W-1:0] ST_REL_LOOP  = 5'd16;
    localparam logic [PC_W-1:0] ST_REL_DONE  = 5'd17;

    // Microprogram: on a true condition jump to target, else step on
    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            ST_WAIT:     w = '{OP_ACCEPT,    C_NO_INPUT,   ST_WAIT};
            ST_CHK_REL:  w = '{OP_NOP,       C_KIND_REL,   ST_REL};
            ST_CHK_LREQ: w = '{OP_NOP,       C_KIND_LREQ,  ST_LREQ};
            ST_CHK_IGN:  w = '{OP_NOP,       C_IGNORE,     ST_WAIT};
            ST_RECV:     w = '{OP_RECV_CLK,  C_KIND_PERM,  ST_PERM_IN};
            ST_CHK_DEF:  w = '{OP_NOP,       C_NOT_DEFER,  ST_PERM_NOW};
            ST_DEFER:    w = '{OP_SET_DEFER, C_ALWAYS,     ST_WAIT};
            ST_PERM_NOW: w = '{OP_EMIT_PERM, C_ALWAYS,     ST_WAIT};
            ST_PERM_IN:  w = '{OP_DEC_PEND,  C_NO_GRANT,   ST_WAIT};
            ST_GRANT:    w = '{OP_EMIT_GRNT, C_ALWAYS,     ST_WAIT};
            ST_LREQ:     w = '{OP_NOP,       C_WANTED,     ST_WAIT};
            ST_REQ_INIT: w = '{OP_START_REQ, C_NEVER,      ST_WAIT};
            ST_REQ_LOOP: w = '{OP_SEND_REQ,  C_REQ_MORE,   ST_REQ_LOOP};
            ST_REQ_DONE: w = '{OP_NOP,       C_ALWAYS,     ST_WAIT};
            ST_REL:      w = '{OP_NOP,       C_NOT_WANTED, ST_WAIT};
            ST_REL_INIT: w = '{OP_START_REL, C_NEVER,      ST_WAIT};
            ST_REL_LOOP: w = '{OP_SEND_REL,  C_REL_MORE,   ST_REL_LOOP};
            ST_REL_DONE: w = '{OP_END_REL,   C_ALWAYS,     ST_WAIT};
            default:     w = '{OP_NOP,       C_ALWAYS,     ST_WAIT};
        endcase
        return w;
    endfunction

    // Saturating clock increment
    function automatic logic [STAMP_W-1:0] clock_inc(logic [STAMP_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Resource number folded into the resource range
    typedef logic [255:0][RES_W-1:0] t_res_tab;

    function automatic t_res_tab build_res_tab();
        t_res_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = RES_W'(i % RESOURCE_COUNT);
        end
        return t;
    endfunction

    localparam t_res_tab RES_FOLD = build_res_tab();

endpackage

`default_nettype wire

// ----- rtl/dmn_seq.sv -----
`default_nettype none

module dmn_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dmn_pkg::t_stat i_stat,
    input  wire logic          i_out_free,
    output dmn_pkg::t_cmd      o_cmd
);
    import dmn_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          uw;
    logic            cond_true;
    logic            stall;

    // Fetch the control word for this step
    assign uw = ucode(r_pc);

    // Evaluate the jump condition
    always_comb begin
        case (uw.cond)
            C_NEVER:      cond_true = 1'b0;
            C_ALWAYS:     cond_true = 1'b1;
            C_NO_INPUT:   cond_true = !i_stat.has_input;
            C_KIND_REL:   cond_true = i_stat.kind_rel;
            C_KIND_LREQ:  cond_true = i_stat.kind_lreq;
            C_IGNORE:     cond_true = i_stat.ignore;
            C_KIND_PERM:  cond_true = i_stat.kind_perm;
            C_NOT_DEFER:  cond_true = i_stat.no_defer;
            C_NO_GRANT:   cond_true = i_stat.no_grant;
            C_WANTED:     cond_true = i_stat.wanted;
            C_NOT_WANTED: cond_true = !i_stat.wanted;
            C_REQ_MORE:   cond_true = i_stat.req_more;
            C_REL_MORE:   cond_true = i_stat.rel_more;
            default:      cond_true = 1'b0;
        endcase
    end

    // Hold the step while a message waits for the output register
    assign stall = i_stat.emit_want && !i_out_free;

    always_comb begin
        if (stall) begin
            n_pc = r_pc;
        end else if (cond_true) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_cmd.op = uw.op;
    assign o_cmd.en = !stall;

endmodule

`default_nettype wire

// ----- rtl/dmn_dp.sv -----
`default_nettype none

module dmn_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire dmn_pkg::t_cmd                i_cmd,
    input  wire logic                         i_in_valid,
    input  wire logic [dmn_pkg::KIND_W-1:0]   i_in_kind,
    input  wire logic [dmn_pkg::NODE_W-1:0]   i_in_sender,
    input  wire logic [dmn_pkg::STAMP_W-1:0]  i_in_stamp,
    input  wire logic [dmn_pkg::RES_W-1:0]    i_in_res,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_idx,
    input  wire logic [dmn_pkg::CNT_W-1:0]    i_cfg_data,
    output dmn_pkg::t_stat                    o_stat,
    output dmn_pkg::t_msg                     o_msg
);
    import dmn_pkg::*;

    // Configuration
    logic [NODE_W-1:0]  r_node_id;
    logic [CNT_W-1:0]   r_node_count;

    // Node state
    logic [STAMP_W-1:0] r_clock;
    logic [STAMP_W-1:0] r_req_stamp;
    logic               r_wanted;
    logic [RES_W-1:0]   r_want_res;
    logic [NODE_W-1:0]  r_pend;
    logic [MASK_W-1:0]  r_mask;

    // Working registers of the current item
    logic [KIND_W-1:0]  r_kind;
    logic [NODE_W-1:0]  r_sender;
    logic [STAMP_W-1:0] r_stamp;
    logic [RES_W-1:0]   r_res;
    logic [STAMP_W-1:0] r_before;
    logic [NODE_W-1:0]  r_iter;

    logic [CNT_W-1:0]   n_eff;
    logic               id_in_range;
    logic [NODE_W-1:0]  last_dest;
    logic [NODE_W-1:0]  pend_load;
    logic [STAMP_W-1:0] clk_max;
    logic               defer;
    logic [MASK_W-1:0]  mask_rest;
    logic [NODE_W-1:0]  low_idx;
    logic               is_op;

    // Clamp the node count to the supported range
    always_comb begin
        if (r_node_count < 5'd2) begin
            n_eff = 5'd2;
        end else if (r_node_count > NODE_CAP) begin
            n_eff = NODE_CAP;
        end else begin
            n_eff = r_node_count;
        end
    end

    // Request fan-out: last destination and number of permissions to await
    assign id_in_range = {1'b0, r_node_id} < n_eff;
    assign last_dest   = (id_in_range && ({1'b0, r_node_id} == n_eff - 5'd1))
                         ? NODE_W'(n_eff - 5'd2) : NODE_W'(n_eff - 5'd1);
    assign pend_load   = id_in_range ? NODE_W'(n_eff - 5'd1) : NODE_W'(n_eff);

    // Receive clock update
    assign clk_max = (r_clock > r_stamp) ? r_clock : r_stamp;

    // Defer when this node wants the same resource and holds priority
    assign defer = r_wanted && (r_res == r_want_res) &&
                   !((r_stamp < r_req_stamp) ||
                     ((r_stamp == r_req_stamp) && (r_sender < r_node_id)));

    // Lowest deferred node and what remains after it
    assign mask_rest = r_mask & (r_mask - 1'b1);

    always_comb begin
        low_idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = NODE_W'(i);
            end
        end
    end

    // Status for the sequencer
    always_comb begin
        o_stat.has_input = i_in_valid;
        o_stat.kind_rel  = (r_kind == RT_RELEASE);
        o_stat.kind_lreq = (r_kind == RT_LOCAL_REQ);
        o_stat.ignore    = (r_sender == r_node_id) || ({1'b0, r_sender} >= n_eff);
        o_stat.kind_perm = (r_kind == RT_RECV_PERM);
        o_stat.no_defer  = !defer;
        o_stat.no_grant  = !(r_wanted && (r_pend == 4'd1));
        o_stat.wanted    = r_wanted;
        o_stat.req_more  = (r_iter != last_dest);
        o_stat.rel_more  = (mask_rest != '0);
        o_stat.mask_any  = (r_mask != '0);
        case (i_cmd.op)
            OP_EMIT_PERM, OP_EMIT_GRNT: o_stat.emit_want = 1'b1;
            OP_SEND_REQ:  o_stat.emit_want = (r_iter != r_node_id);
            OP_SEND_REL:  o_stat.emit_want = (r_mask != '0);
            default:      o_stat.emit_want = 1'b0;
        endcase
    end

    // Message for the output register
    always_comb begin
        case (i_cmd.op)
            OP_EMIT_PERM: o_msg = '{MK_PERMISSION, r_sender, r_before, r_res, 1'b1};
            OP_EMIT_GRNT: o_msg = '{MK_GRANT, r_node_id, r_clock, r_want_res, 1'b1};
            OP_SEND_REQ:  o_msg = '{MK_REQUEST, r_iter, r_req_stamp, r_want_res,
                                    (r_iter == last_dest)};
            default:      o_msg = '{MK_PERMISSION, low_idx, r_clock, r_want_res,
                                    (mask_rest == '0)};
        endcase
    end

    assign is_op = i_cmd.en;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id    <= '0;
            r_node_count <= 5'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NODE_ID:    r_node_id    <= i_cfg_data[NODE_W-1:0];
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                default:        r_node_count <= r_node_count;
            endcase
        end
    end

    // Node state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock     <= '0;
            r_req_stamp <= '0;
            r_wanted    <= 1'b0;
            r_want_res  <= '0;
            r_pend      <= '0;
            r_mask      <= '0;
        end else if (is_op) begin
            case (i_cmd.op)
                OP_RECV_CLK: begin
                    r_clock <= clock_inc(clk_max);
                end
                OP_SET_DEFER: begin
                    r_mask <= r_mask | (MASK_W'(1) << r_sender);
                end
                OP_DEC_PEND: begin
                    if (r_wanted && (r_pend != '0)) begin
                        r_pend <= r_pend - 1'b1;
                    end
                end
                OP_START_REQ: begin
                    r_clock     <= clock_inc(r_clock);
                    r_req_stamp <= clock_inc(r_clock);
                    r_wanted    <= 1'b1;
                    r_want_res  <= r_res;
                    r_pend      <= pend_load;
                end
                OP_START_REL: begin
                    r_clock <= clock_inc(r_clock);
                end
                OP_SEND_REL: begin
                    r_mask <= mask_rest;
                end
                OP_END_REL: begin
                    r_mask   <= '0;
                    r_wanted <= 1'b0;
                    r_pend   <= '0;
                end
                default: begin
                    r_mask <= r_mask;
                end
            endcase
        end
    end

    // Working registers: latch the item, save the prior clock, walk nodes
    always_ff @(posedge i_clk) begin
        if (is_op) begin
            case (i_cmd.op)
                OP_ACCEPT: begin
                    if (i_in_valid) begin
                        r_kind   <= i_in_kind;
                        r_sender <= i_in_sender;
                        r_stamp  <= i_in_stamp;
                        r_res    <= RES_FOLD[i_in_res];
                    end
                end
                OP_RECV_CLK:  r_before <= r_clock;
                OP_START_REQ: r_iter   <= '0;
                OP_SEND_REQ:  r_iter   <= r_iter + 1'b1;
                default:      r_iter   <= r_iter;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/distributed_mutex_node.sv -----
// A received item passes the release, local-request and ignore checks and the clock update;
// a request is then deferred or answered with a permission, a permission may give the grant.
// A local request walks the nodes, one request per other node per cycle while the output is free,
// stepping over this node without a message. The node takes one item at a time, a new one only
// in the wait step; a release sends a permission to each deferred node, one after another.
// Reset: synchronous, active low; clears the whole node state, no clearing pass.
`default_nettype none

module distributed_mutex_node (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Input stream
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [dmn_pkg::DATA_W-1:0]  s_tdata,  // sender_node, sender_stamp, resource_id
    input  wire logic [dmn_pkg::KIND_W-1:0]  s_tuser,  // req_type
    // Output stream
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [dmn_pkg::DATA_W-1:0]       m_tdata,  // dest_node, clock_stamp, out_resource
    output logic [dmn_pkg::KIND_W-1:0]       m_tuser,  // msg_kind
    output logic                             m_tlast,
    // Configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [dmn_pkg::CNT_W-1:0]   i_cfg_data
);
    import dmn_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_msg  msg;
    logic  out_free;
    logic  out_load;
    logic  r_out_valid;
    t_msg  r_out;

    dmn_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .i_out_free (out_free),
        .o_cmd      (cmd)
    );

    dmn_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_valid  (s_tvalid),
        .i_in_kind   (s_tuser),
        .i_in_sender (s_tdata[3:0]),
        .i_in_stamp  (s_tdata[35:4]),
        .i_in_res    (s_tdata[43:36]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_msg       (msg)
    );

    assign s_tready = (cmd.op == OP_ACCEPT);

    // Output register: take a new beat when empty or being drained
    assign out_free = !r_out_valid || m_tready;
    assign out_load = stat.emit_want && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= msg;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.kind;
    assign m_tlast  = r_out.last;
    assign m_tdata  = {4'd0, r_out.res, r_out.stamp, r_out.dest};

    // Nothing stays deferred once the request is withdrawn
    a_mask_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.wanted |-> !stat.mask_any)
        else $error("deferred nodes left while not requesting");

    // No message is produced while waiting for an input item
    a_quiet_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !out_load)
        else $error("message produced in wait step");

    // The final beat of a fan-out returns the sequencer to its wait step
    a_loop_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && msg.last && (cmd.op == OP_SEND_REQ || cmd.op == OP_SEND_REL))
        |-> ##2 s_tready)
        else $error("sequencer did not return after the last beat");

endmodule

`default_nettype wire
